// ===== rtl/tpr_pkg.sv =====
// ----------------------------------------------------------------------------
// tpr_pkg
// Shared types, key table and codes for the tagged record text parser.
// ----------------------------------------------------------------------------
package tpr_pkg;

  // Default depth of the held-whitespace store
  localparam int SPACE_FIFO_DEPTH_DEF = 16;

  localparam int NUM_KEYS = 26;

  // Result kinds
  localparam logic [1:0] KIND_STR_BYTE = 2'd0;
  localparam logic [1:0] KIND_STR_END  = 2'd1;
  localparam logic [1:0] KIND_NUMBER   = 2'd2;
  localparam logic [1:0] KIND_DONE     = 2'd3;

  // Characters of interest
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  typedef enum logic [1:0] {
    KC_STR,
    KC_NUM,
    KC_SKIP
  } key_class_t;

  // Hash of each known key, in tag order
  localparam logic [31:0] KEY_HASH [NUM_KEYS] = '{
    32'd761,   32'd7924,  32'd12189, 32'd715,   32'd3051,  32'd408,   32'd6058,
    32'd726,   32'd24269, 32'd97997, 32'd14004, 32'd3506,  32'd921,   32'd1513,
    32'd1753,  32'd15204, 32'd1466,  32'd1508,  32'd2804,  32'd5867,  32'd61355,
    32'd24435, 32'd14188, 32'd2932,  32'd2966,  32'd697
  };

  localparam key_class_t KEY_CLASS [NUM_KEYS] = '{
    KC_STR,  KC_STR,  KC_STR,  KC_STR,  KC_SKIP, KC_STR,  KC_SKIP, KC_STR,  KC_NUM,
    KC_NUM,  KC_STR,  KC_NUM,  KC_NUM,  KC_NUM,  KC_NUM,  KC_SKIP, KC_SKIP, KC_SKIP,
    KC_SKIP, KC_SKIP, KC_SKIP, KC_SKIP, KC_SKIP, KC_SKIP, KC_STR,  KC_STR
  };

  // Input request
  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_record;
  } rec_t;

  // Result
  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  tag_id;
    logic [7:0]  text_byte;
    logic [31:0] number_value;
    logic        status;
    logic        final_result;
  } res_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] idx;
    key_class_t cls;
  } key_match_t;

  // Controller to datapath
  typedef struct packed {
    logic latch;        // capture the accepted request
    logic main_go;      // process the byte
    logic use_latched;  // byte comes from the latch, not the port
    logic flush_rd;     // read held whitespace at the flush index
    logic flush_emit;   // emit the held byte just read
    logic finish_go;    // close the open field
    logic done_go;      // emit record done and clear state
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic can_push;       // result queue has room
    logic in_slow;        // port byte needs more than one step
    logic in_need_flush;  // port byte releases held whitespace first
    logic in_zero;        // port byte is zero
    logic lat_eor;        // latched request ends the record
    logic flush_last;     // flush index is at the last held byte
  } status_t;

  function automatic key_match_t key_lookup(input logic [31:0] h);
    key_match_t m;
    m.hit = 1'b0;
    m.idx = '0;
    m.cls = KC_SKIP;
    for (int i = 0; i < NUM_KEYS; i++) begin
      if (KEY_HASH[i] == h) begin
        m.hit = 1'b1;
        m.idx = 5'(i);
        m.cls = KEY_CLASS[i];
      end
    end
    return m;
  endfunction

  function automatic logic is_ws(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

endpackage

// ===== rtl/tpr_ram.sv =====
// ----------------------------------------------------------------------------
// tpr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/tpr_ctrl.sv =====
// ----------------------------------------------------------------------------
// tpr_ctrl
// Sequencer: takes a request, runs flush / main / finish / done steps.
// ----------------------------------------------------------------------------
module tpr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             rec_valid,
  output logic             rec_ready,
  input  tpr_pkg::status_t sts,
  output tpr_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FL_RD,
    ST_FL_EMIT,
    ST_MAIN,
    ST_FINISH,
    ST_DONE
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign rec_ready = (state == ST_IDLE) && sts.can_push;
  assign accept    = rec_valid && rec_ready;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (!sts.in_slow) begin
            cmd.main_go = 1'b1;
          end else begin
            cmd.latch = 1'b1;
            if (sts.in_need_flush) begin
              state_next = ST_FL_RD;
            end else if (!sts.in_zero) begin
              state_next = ST_MAIN;
            end else begin
              state_next = ST_FINISH;
            end
          end
        end
      end
      ST_FL_RD: begin
        cmd.flush_rd = 1'b1;
        state_next   = ST_FL_EMIT;
      end
      ST_FL_EMIT: begin
        if (sts.can_push) begin
          cmd.flush_emit = 1'b1;
          state_next     = sts.flush_last ? ST_MAIN : ST_FL_RD;
        end
      end
      ST_MAIN: begin
        if (sts.can_push) begin
          cmd.main_go     = 1'b1;
          cmd.use_latched = 1'b1;
          state_next      = sts.lat_eor ? ST_FINISH : ST_IDLE;
        end
      end
      ST_FINISH: begin
        if (sts.can_push) begin
          cmd.finish_go = 1'b1;
          state_next    = sts.lat_eor ? ST_DONE : ST_IDLE;
        end
      end
      ST_DONE: begin
        if (sts.can_push) begin
          cmd.done_go = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  // A latched request always leads to at least one further step
  assert property (@(posedge clk) disable iff (rst)
    cmd.latch |=> (state != ST_IDLE))
    else $error("latched request left no pending step");

  // Record done is only reached for a request that ends the record
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> sts.lat_eor)
    else $error("record done without end of record");
`endif

endmodule

// ===== rtl/tpr_datapath.sv =====
// ----------------------------------------------------------------------------
// tpr_datapath
// Parse state, key hash and lookup, number accumulator, held whitespace
// store and a two-entry result queue.
// ----------------------------------------------------------------------------
module tpr_datapath #(
  parameter int SPACE_FIFO_DEPTH = tpr_pkg::SPACE_FIFO_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  tpr_pkg::rec_t    rec_data,
  input  tpr_pkg::cmd_t    cmd,
  output tpr_pkg::status_t sts,
  output logic             res_valid,
  input  logic             res_ready,
  output tpr_pkg::res_t    res_data
);

  localparam int AW = (SPACE_FIFO_DEPTH > 1) ? $clog2(SPACE_FIFO_DEPTH) : 1;
  localparam int CW = $clog2(SPACE_FIFO_DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(SPACE_FIFO_DEPTH);

  typedef enum logic [2:0] {
    PH_SCAN,
    PH_KEY,
    PH_SKIP1,
    PH_STR_LEAD,
    PH_STR_BODY,
    PH_NUM_LEAD,
    PH_NUM_DIG,
    PH_DRAIN
  } phase_t;

  // Parse state
  phase_t        phase, phase_next;
  logic [31:0]   key_hash, key_hash_next;
  logic [4:0]    cur_tag, cur_tag_next;
  logic [31:0]   accum, accum_next;
  logic [CW-1:0] pend_count, pend_count_next;
  logic          error_seen, error_seen_next;
  logic [AW-1:0] fl_idx, fl_idx_next;

  // Latched request
  logic [7:0]    lat_byte;
  logic          lat_eor;

  // Held whitespace store
  logic          ram_we;
  logic [7:0]    ram_rdata;

  // Result queue
  tpr_pkg::res_t q0, q1;
  logic [1:0]    q_count;
  logic          push, pop;
  tpr_pkg::res_t push_data;

  logic [7:0]           sel_b;
  logic                 sel_ws, sel_digit, in_ws;
  tpr_pkg::key_match_t  lk;
  phase_t               lk_phase;
  phase_t               fin_phase;
  logic [4:0]           fin_tag;
  logic [31:0]          fin_accum;

  assign sel_b     = cmd.use_latched ? lat_byte : rec_data.byte_value;
  assign sel_ws    = tpr_pkg::is_ws(sel_b);
  assign sel_digit = (sel_b >= tpr_pkg::CH_ZERO) && (sel_b <= tpr_pkg::CH_NINE);
  assign in_ws     = tpr_pkg::is_ws(rec_data.byte_value);

  assign lk = tpr_pkg::key_lookup(key_hash);

  always_comb begin
    unique case (lk.cls)
      tpr_pkg::KC_STR: lk_phase = PH_STR_LEAD;
      tpr_pkg::KC_NUM: lk_phase = PH_NUM_LEAD;
      default:         lk_phase = PH_SKIP1;
    endcase
  end

  // Status towards the controller
  always_comb begin
    sts.can_push      = (q_count != 2'd2);
    sts.in_zero       = (rec_data.byte_value == 8'd0);
    sts.in_need_flush = !sts.in_zero && (phase == PH_STR_BODY) &&
                        ((in_ws && (rec_data.byte_value != tpr_pkg::CH_LF) &&
                          (pend_count == FULL_COUNT)) ||
                         (!in_ws && (pend_count != '0)));
    sts.in_slow       = sts.in_zero || rec_data.end_of_record || sts.in_need_flush;
    sts.lat_eor       = lat_eor;
    sts.flush_last    = ((CW'(fl_idx) + CW'(1)) == pend_count);
  end

  // Field close as seen at end of record or zero byte
  always_comb begin
    fin_phase = phase;
    fin_tag   = cur_tag;
    fin_accum = accum;
    if (phase == PH_KEY) begin
      if (lk.hit) begin
        fin_phase = lk_phase;
        fin_tag   = lk.idx;
        fin_accum = '0;
      end else begin
        fin_phase = PH_DRAIN;
      end
    end
  end

  // Step logic
  always_comb begin
    phase_next      = phase;
    key_hash_next   = key_hash;
    cur_tag_next    = cur_tag;
    accum_next      = accum;
    pend_count_next = pend_count;
    error_seen_next = error_seen;
    fl_idx_next     = fl_idx;
    ram_we          = 1'b0;
    push            = 1'b0;
    push_data       = '0;
    push_data.tag_id = cur_tag;

    if (cmd.main_go) begin
      push_data.final_result = cmd.use_latched ? !lat_eor : 1'b1;
      unique case (phase)
        PH_SCAN: begin
          if (sel_b == tpr_pkg::CH_PERCENT) begin
            phase_next    = PH_KEY;
            key_hash_next = '0;
          end
        end
        PH_KEY: begin
          if (sel_b == tpr_pkg::CH_PERCENT) begin
            if (lk.hit) begin
              cur_tag_next    = lk.idx;
              accum_next      = '0;
              pend_count_next = '0;
              phase_next      = lk_phase;
            end else begin
              error_seen_next = 1'b1;
              phase_next      = PH_DRAIN;
            end
          end else begin
            key_hash_next = key_hash + ({24'd0, sel_b} | key_hash);
          end
        end
        PH_SKIP1: phase_next = PH_SCAN;
        PH_STR_LEAD: begin
          if (!sel_ws) begin
            push                = 1'b1;
            push_data.kind      = tpr_pkg::KIND_STR_BYTE;
            push_data.text_byte = sel_b;
            phase_next          = PH_STR_BODY;
          end
        end
        PH_STR_BODY: begin
          if (sel_b == tpr_pkg::CH_LF) begin
            pend_count_next = '0;
            push            = 1'b1;
            push_data.kind  = tpr_pkg::KIND_STR_END;
            phase_next      = PH_SCAN;
          end else if (sel_ws) begin
            // hold it; any earlier full store has been flushed already
            ram_we          = 1'b1;
            pend_count_next = pend_count + CW'(1);
          end else begin
            push                = 1'b1;
            push_data.kind      = tpr_pkg::KIND_STR_BYTE;
            push_data.text_byte = sel_b;
          end
        end
        PH_NUM_LEAD, PH_NUM_DIG: begin
          if (sel_digit) begin
            accum_next = (accum << 3) + (accum << 1) + {24'd0, sel_b - tpr_pkg::CH_ZERO};
            phase_next = PH_NUM_DIG;
          end else if ((phase == PH_NUM_LEAD) && sel_ws) begin
            phase_next = phase;
          end else begin
            push                   = 1'b1;
            push_data.kind         = tpr_pkg::KIND_NUMBER;
            push_data.number_value = accum;
            phase_next             = PH_SCAN;
          end
        end
        default: phase_next = phase;
      endcase
    end else if (cmd.flush_emit) begin
      push                   = 1'b1;
      push_data.kind         = tpr_pkg::KIND_STR_BYTE;
      push_data.text_byte    = ram_rdata;
      push_data.final_result = sts.flush_last && !lat_eor && tpr_pkg::is_ws(lat_byte);
      if (sts.flush_last) begin
        fl_idx_next     = '0;
        pend_count_next = '0;
      end else begin
        fl_idx_next = fl_idx + AW'(1);
      end
    end else if (cmd.finish_go) begin
      cur_tag_next           = fin_tag;
      accum_next             = fin_accum;
      push_data.tag_id       = fin_tag;
      push_data.final_result = !lat_eor;
      if ((phase == PH_KEY) && !lk.hit) begin
        error_seen_next = 1'b1;
      end
      if ((phase == PH_KEY) && lk.hit) begin
        pend_count_next = '0;
      end
      if ((fin_phase == PH_STR_LEAD) || (fin_phase == PH_STR_BODY)) begin
        pend_count_next = '0;
        push            = 1'b1;
        push_data.kind  = tpr_pkg::KIND_STR_END;
      end else if ((fin_phase == PH_NUM_LEAD) || (fin_phase == PH_NUM_DIG)) begin
        push                   = 1'b1;
        push_data.kind         = tpr_pkg::KIND_NUMBER;
        push_data.number_value = fin_accum;
      end
      phase_next = PH_DRAIN;
    end else if (cmd.done_go) begin
      push                   = 1'b1;
      push_data.kind         = tpr_pkg::KIND_DONE;
      push_data.tag_id       = '0;
      push_data.status       = error_seen;
      push_data.final_result = 1'b1;
      phase_next             = PH_SCAN;
      key_hash_next          = '0;
      cur_tag_next           = '0;
      accum_next             = '0;
      pend_count_next        = '0;
      error_seen_next        = 1'b0;
      fl_idx_next            = '0;
    end
  end

  // Parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_SCAN;
      key_hash   <= '0;
      cur_tag    <= '0;
      accum      <= '0;
      pend_count <= '0;
      error_seen <= 1'b0;
      fl_idx     <= '0;
    end else begin
      phase      <= phase_next;
      key_hash   <= key_hash_next;
      cur_tag    <= cur_tag_next;
      accum      <= accum_next;
      pend_count <= pend_count_next;
      error_seen <= error_seen_next;
      fl_idx     <= fl_idx_next;
    end
  end

  // Request latch
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      lat_byte <= rec_data.byte_value;
      lat_eor  <= rec_data.end_of_record;
    end
  end

  tpr_ram #(
    .WIDTH(8),
    .DEPTH(SPACE_FIFO_DEPTH)
  ) u_space_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(pend_count[AW-1:0]),
    .wdata(sel_b),
    .re   (cmd.flush_rd),
    .raddr(fl_idx),
    .rdata(ram_rdata)
  );

  // Two-entry result queue
  assign res_valid = (q_count != 2'd0);
  assign res_data  = q0;
  assign pop       = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_count <= '0;
    end else begin
      unique case ({push, pop})
        2'b10:   q_count <= q_count + 2'd1;
        2'b01:   q_count <= q_count - 2'd1;
        default: q_count <= q_count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (push && (q_count == 2'd1)) begin
        q0 <= push_data;
      end else begin
        q0 <= q1;
      end
      if (push && (q_count == 2'd2)) begin
        q1 <= push_data;
      end
    end else if (push) begin
      if (q_count == 2'd0) begin
        q0 <= push_data;
      end else begin
        q1 <= push_data;
      end
    end
  end

`ifndef SYNTHESIS
  // Whitespace is never written into a full store
  assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (pend_count < FULL_COUNT))
    else $error("held whitespace written into full store");

  // Result queue never overflows
  assert property (@(posedge clk) disable iff (rst)
    push |-> (q_count != 2'd2))
    else $error("result queue overflow");

  // Flush reads stay within the held bytes
  assert property (@(posedge clk) disable iff (rst)
    cmd.flush_rd |-> (CW'(fl_idx) < pend_count))
    else $error("flush read beyond held bytes");

  // Record done leaves the parser scanning with nothing held
  assert property (@(posedge clk) disable iff (rst)
    cmd.done_go |=> ((phase == PH_SCAN) && (pend_count == '0) && !error_seen))
    else $error("state not cleared after record done");
`endif

endmodule

// ===== rtl/tagged_record_text_parser_core.sv =====
// ----------------------------------------------------------------------------
// tagged_record_text_parser_core
// Parses %KEY% records byte by byte into string, number and record-done
// results.
// ----------------------------------------------------------------------------
//  channel | valid     | ready     | payload  | moves
//  --------+-----------+-----------+----------+------------------------------
//  input   | rec_valid | rec_ready | rec_data | one record byte per request
//  output  | res_valid | res_ready | res_data | one result per request
//
//  An ordinary byte is processed in the cycle it is accepted and gives at most one result.
//  Any other byte is first latched, then each held whitespace byte it
//  releases takes a RAM read, then a result; then comes the byte itself
//  unless it is zero, then the field close on a zero byte or end of
//  record, and record done at end of record. rec_ready is low until
//  the sequencer is idle again and while the two-entry result queue is full.
//  Reset is synchronous; no clearing pass follows it.
// ----------------------------------------------------------------------------
module tagged_record_text_parser_core #(
  parameter int SPACE_FIFO_DEPTH = tpr_pkg::SPACE_FIFO_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rec_valid,
  output logic          rec_ready,
  input  tpr_pkg::rec_t rec_data,
  output logic          res_valid,
  input  logic          res_ready,
  output tpr_pkg::res_t res_data
);

  tpr_pkg::cmd_t    cmd;
  tpr_pkg::status_t sts;

  tpr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .rec_valid(rec_valid),
    .rec_ready(rec_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tpr_datapath #(
    .SPACE_FIFO_DEPTH(SPACE_FIFO_DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .rec_data (rec_data),
    .cmd      (cmd),
    .sts      (sts),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_data (res_data)
  );

endmodule
